@@ src/fslf_pkg.sv @@
// Shared types and constants of the fixed-string line filter.
package fslf_pkg;

  localparam int BYTE_W       = 8;
  localparam int LINE_NUM_W   = 32;
  localparam int PLEN_W       = 5;
  localparam int PAT_BYTES    = 16;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_ADDR_W   = 5;
  localparam int CFG_IDX_W    = 2;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'd10;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

  typedef struct packed {
    logic [2*CFG_DATA_W-1:0] pattern;
    logic [PLEN_W-1:0]       pattern_length;
  } cfg_t;

  typedef struct packed {
    logic step;
    logic clear;
  } match_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND,
    ST_NL
  } state_t;

endpackage

@@ src/fslf_if.sv @@
// Stream interfaces for input bytes and emitted line words.
interface fslf_in_if;
  import fslf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_marker;

  modport source (output valid, output in_byte, output end_marker, input ready);
  modport sink   (input valid, input in_byte, input end_marker, output ready);
endinterface

interface fslf_out_if;
  import fslf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [BYTE_W-1:0]     out_byte;
  logic [LINE_NUM_W-1:0] line_number;
  logic                  line_end;
  logic                  truncated;

  modport source (output valid, output out_byte, output line_number, output line_end,
                  output truncated, input ready);
  modport sink   (input valid, input out_byte, input line_number, input line_end,
                  input truncated, output ready);
endinterface

@@ src/fslf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fslf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/fslf_cfg.sv @@
// APB register bank holding the search pattern and its length.
module fslf_cfg
  import fslf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [PLEN_W-1:0]     pattern_length;
  logic [CFG_IDX_W-1:0]  reg_idx;
  logic                  wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-CFG_IDX_W];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PATTERN_LOW:    pattern_low    <= pwdata;
        REG_PATTERN_HIGH:   pattern_high   <= pwdata;
        REG_PATTERN_LENGTH: pattern_length <= pwdata[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PATTERN_LOW:    prdata = pattern_low;
      REG_PATTERN_HIGH:   prdata = pattern_high;
      REG_PATTERN_LENGTH: prdata = CFG_DATA_W'(pattern_length);
      default:            prdata = '0;
    endcase
  end

  assign cfg.pattern        = {pattern_high, pattern_low};
  assign cfg.pattern_length = pattern_length;

endmodule

@@ src/fslf_match.sv @@
// Sliding window of recent bytes and the per-line found flag.
module fslf_match
  import fslf_pkg::*;
#(
  parameter int PATTERN_MAX = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  match_ctl_t        ctl,
  input  logic [BYTE_W-1:0] cur_byte,
  input  cfg_t              cfg,
  output logic              found
);

  localparam int WIN    = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
  localparam int FILL_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [BYTE_W-1:0] recent [WIN];
  logic [FILL_W-1:0] window_fill;
  logic [BYTE_W-1:0] back [PATTERN_MAX];
  logic [BYTE_W-1:0] pat  [PAT_BYTES];
  logic              all_eq;
  logic              win_ok;
  logic              len_ok;
  logic              hit;

  always_comb begin
    logic [PLEN_W-1:0] j;
    j = '0;
    back[0] = cur_byte;
    for (int d = 1; d < PATTERN_MAX; d++) begin
      back[d] = recent[d-1];
    end
    for (int k = 0; k < PAT_BYTES; k++) begin
      pat[k] = cfg.pattern[BYTE_W*k +: BYTE_W];
    end
    // byte d places back lines up with pattern byte length-1-d
    all_eq = 1'b1;
    for (int d = 0; d < PATTERN_MAX; d++) begin
      if (PLEN_W'(d) < cfg.pattern_length) begin
        j = cfg.pattern_length - PLEN_W'(1) - PLEN_W'(d);
        if (back[d] != pat[j[$clog2(PAT_BYTES)-1:0]]) begin
          all_eq = 1'b0;
        end
      end
    end
  end

  assign len_ok = (cfg.pattern_length != '0) &&
                  (cfg.pattern_length <= PLEN_W'(PATTERN_MAX));
  assign win_ok = (PLEN_W'(window_fill) + PLEN_W'(1)) >= cfg.pattern_length;
  assign hit    = len_ok && win_ok && all_eq;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill <= '0;
      found       <= 1'b0;
      for (int k = 0; k < WIN; k++) begin
        recent[k] <= '0;
      end
    end else if (ctl.clear) begin
      window_fill <= '0;
      found       <= 1'b0;
    end else if (ctl.step) begin
      if (hit) begin
        found <= 1'b1;
      end
      recent[0] <= cur_byte;
      for (int k = 1; k < WIN; k++) begin
        recent[k] <= recent[k-1];
      end
      if (window_fill < FILL_W'(PATTERN_MAX - 1)) begin
        window_fill <= window_fill + FILL_W'(1);
      end
    end
  end

endmodule

@@ src/fixed_string_line_filter_top.sv @@
// Fixed-string line filter: passes only the lines that contain a configured byte string.
//
// stream takes one byte per word (or an end marker); filtered gives the words of
// each matching line, closed by a newline word with line_end set. Every word
// carries the 1-based line number and the truncated flag of its line.
// The pattern (up to 16 bytes) and its length are set over the APB port;
// length zero passes nothing. Write it only while the block is idle.
// An ordinary byte is matched against the window and written into the line
// RAM. A newline or end marker closes the line; on a match the line is drained
// from the line RAM, each stored byte read from the RAM and then presented as a
// word, followed by the newline word.
// stream is held off while a line drains; the drain waits as long as the
// receiver stalls filtered.
// Lines longer than LINE_BYTES are matched in full but emitted cut.
// Reset clears the line state and sets the line number to one; the pattern
// registers reset to zero. The end marker also returns the line number to one.
module fixed_string_line_filter_top
  import fslf_pkg::*;
#(
  parameter int LINE_BYTES  = 63,
  parameter int PATTERN_MAX = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  fslf_in_if.sink               stream,
  fslf_out_if.source            filtered,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int LEN_W = $clog2(LINE_BYTES + 1);
  localparam int AW    = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;

  cfg_t                  cfg;
  match_ctl_t            mctl;
  logic                  found;
  state_t                state, state_next;

  logic [LEN_W-1:0]      line_length;
  logic                  overflowed;
  logic [LINE_NUM_W-1:0] current_line;
  logic [LEN_W-1:0]      drain_len;
  logic [LINE_NUM_W-1:0] drain_line;
  logic                  drain_trunc;
  logic [LEN_W-1:0]      rd_idx;

  logic                  in_fire;
  logic                  is_close;
  logic                  line_hit;
  logic                  ram_we;
  logic                  ram_re;
  logic [BYTE_W-1:0]     ram_rdata;

  fslf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fslf_match #(.PATTERN_MAX(PATTERN_MAX)) u_match (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mctl),
    .cur_byte (stream.in_byte),
    .cfg      (cfg),
    .found    (found)
  );

  fslf_ram #(.WIDTH(BYTE_W), .DEPTH(LINE_BYTES)) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (line_length[AW-1:0]),
    .wdata (stream.in_byte),
    .re    (ram_re),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign in_fire    = stream.valid && stream.ready;
  assign is_close   = stream.end_marker || (stream.in_byte == NEWLINE);
  assign line_hit   = found && (cfg.pattern_length != '0) &&
                      (cfg.pattern_length <= PLEN_W'(PATTERN_MAX));
  assign mctl.step  = in_fire && !is_close;
  assign mctl.clear = in_fire && is_close;
  assign ram_we     = mctl.step && (line_length < LEN_W'(LINE_BYTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    stream.ready   = 1'b0;
    filtered.valid = 1'b0;
    ram_re         = 1'b0;
    case (state)
      ST_IDLE: begin
        stream.ready = 1'b1;
        if (in_fire && is_close && line_hit) begin
          state_next = (line_length == '0) ? ST_NL : ST_READ;
        end
      end
      ST_READ: begin
        ram_re     = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        filtered.valid = 1'b1;
        if (filtered.ready) begin
          state_next = (rd_idx + LEN_W'(1) == drain_len) ? ST_NL : ST_READ;
        end
      end
      ST_NL: begin
        filtered.valid = 1'b1;
        if (filtered.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // line bookkeeping and drain snapshot
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length  <= '0;
      overflowed   <= 1'b0;
      current_line <= LINE_NUM_W'(1);
      rd_idx       <= '0;
    end else begin
      if (in_fire) begin
        if (is_close) begin
          line_length <= '0;
          overflowed  <= 1'b0;
          rd_idx      <= '0;
          if (stream.end_marker) begin
            current_line <= LINE_NUM_W'(1);
          end else if (current_line != '1) begin
            current_line <= current_line + LINE_NUM_W'(1);
          end
        end else if (ram_we) begin
          line_length <= line_length + LEN_W'(1);
        end else begin
          overflowed <= 1'b1;
        end
      end
      if (state == ST_SEND && filtered.ready) begin
        rd_idx <= rd_idx + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_close) begin
      drain_len   <= line_length;
      drain_line  <= current_line;
      drain_trunc <= overflowed;
    end
  end

  assign filtered.out_byte    = (state == ST_NL) ? NEWLINE : ram_rdata;
  assign filtered.line_number = drain_line;
  assign filtered.line_end    = (state == ST_NL);
  assign filtered.truncated   = drain_trunc;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(stream.ready && filtered.valid))
    else $error("input taken while a line drains");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    line_length <= LEN_W'(LINE_BYTES))
    else $error("line length beyond buffer");

  a_send_idx: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND) |-> (rd_idx < drain_len))
    else $error("drain index past line end");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (filtered.valid && filtered.ready && filtered.line_end) |=> stream.ready)
    else $error("block not idle after line end");

endmodule
